// File: hdl/bsac_pkg.sv
// Shared types and constants of the banker's safety and request check block.
`default_nettype none
package bsac_pkg;

  localparam int unsigned WorkW = 24;
  localparam logic [WorkW-1:0] WorkMax = 24'hFFFFFF;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CfgIdxProcesses = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxResources = 4'd1;

  typedef enum logic [2:0] {
    CMD_ALLOC = 3'd0,
    CMD_MAX   = 3'd1,
    CMD_AVAIL = 3'd2,
    CMD_CHECK = 3'd3,
    CMD_REQ   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SEQ     = 3'd0,
    KIND_GRANT   = 3'd1,
    KIND_UNSAFE  = 3'd2,
    KIND_CLAIM   = 3'd3,
    KIND_UNAVAIL = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_PROC,
    ST_CHK,
    ST_ADD,
    ST_SDONE,
    ST_EMIT,
    ST_MARK,
    ST_ONE,
    ST_RQ,
    ST_GR,
    ST_RB
  } state_e;

endpackage
`default_nettype wire

// File: hdl/bsac_in_if.sv
// Command channel: one command word with its handshake.
`default_nettype none
interface bsac_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  process;
  logic [2:0]  resource;
  logic [15:0] value;
  logic        last;
  modport source (output valid, command, process, resource, value, last, input ready);
  modport sink   (input valid, command, process, resource, value, last, output ready);
endinterface
`default_nettype wire

// File: hdl/bsac_out_if.sv
// Result channel: one result word with its handshake.
`default_nettype none
interface bsac_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [3:0] process_index;
  logic       final_res;
  modport source (output valid, kind, process_index, final_res, input ready);
  modport sink   (input valid, kind, process_index, final_res, output ready);
endinterface
`default_nettype wire

// File: hdl/bsac_cfg_if.sv
// Configuration write channel: register index and write data.
`default_nettype none
interface bsac_cfg_if;
  import bsac_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: hdl/bankers_safety_and_request_check.sv
// Banker's algorithm engine: stores, safety scan sequencer and result register.
// Commands arrive on in_i one word at a time and are taken only while the
// sequencer is idle. Writes of allocation, maximum and available entries and
// request elements that are not last give no result.
// A safety check copies the available vector into work and then walks the
// processes pass after pass, one resource element per cycle through a single
// registered read of the allocation and maximum memories and one shared
// compare and saturating adder. A final request element first runs a combined
// claim and availability scan, then a tentative grant if the scan is clean, a
// safety check and, if that check fails, a rollback.
// Results leave through a single output register on out_o; while the
// receiver stalls the sequencer waits before each new word, and the next
// command is taken as soon as the last word of a command sits in the register.
// Reset clears the allocation and maximum memories at once through valid bits
// and the available vector directly, so no clearing pass is needed;
// configuration returns to one process and one resource.
// cfg_i is always ready and should only be written while the block is idle.
`default_nettype none
module bankers_safety_and_request_check
  import bsac_pkg::*;
#(
  parameter int unsigned MAX_PROCESSES = 16,
  parameter int unsigned MAX_RESOURCES = 8,
  parameter int unsigned AMOUNT_WIDTH  = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  bsac_cfg_if.sink      cfg_i,
  bsac_in_if.sink       in_i,
  bsac_out_if.source    out_o
);

  localparam int unsigned PW    = $clog2(MAX_PROCESSES);
  localparam int unsigned RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int unsigned NPW   = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned MW    = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = ((AMOUNT_WIDTH > WorkW) ? AMOUNT_WIDTH : WorkW) + 2;

  typedef logic [AMOUNT_WIDTH-1:0] amt_t;

  function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [RW-1:0] r);
    return AW'(int'(p) * MAX_RESOURCES + int'(r));
  endfunction

  state_e state_q, state_d;

  logic [4:0] num_p_q, num_p_d;
  logic [3:0] num_r_q, num_r_d;
  logic [NPW-1:0] n_eff;
  logic [MW-1:0]  m_eff;

  logic [PW-1:0]  i_q, i_d;
  logic [RW-1:0]  j_q, j_d;
  logic [NPW-1:0] cnt_q, cnt_d;
  logic [NPW-1:0] e_q, e_d;
  logic           prog_q, prog_d;
  logic           req_mode_q, req_mode_d;
  logic           bad_claim_q, bad_claim_d;
  logic           bad_avail_q, bad_avail_d;
  logic [PW-1:0]  p_q, p_d;
  kind_e          res_kind_q, res_kind_d;

  logic [MAX_PROCESSES-1:0]                fin_q, fin_d;
  logic [MAX_PROCESSES-1:0][PW-1:0]        seq_q, seq_d;
  logic [MAX_RESOURCES-1:0][AMOUNT_WIDTH-1:0] avail_q, avail_d;
  logic [MAX_RESOURCES-1:0][AMOUNT_WIDTH-1:0] req_q, req_d;
  logic [MAX_RESOURCES-1:0][WorkW-1:0]     work_q, work_d;

  // Allocation and maximum memories with one write and one registered read each.
  amt_t            alloc_mem [DEPTH];
  amt_t            max_mem   [DEPTH];
  logic [DEPTH-1:0] alloc_vld_q, max_vld_q;
  amt_t            alloc_rd_q, max_rd_q;
  logic            alloc_rv_q, max_rv_q;
  logic            alloc_we, max_we;
  logic [AW-1:0]   alloc_waddr, max_waddr, rd_addr;
  amt_t            alloc_wdata, max_wdata;
  logic [PW-1:0]   rd_p;
  logic [RW-1:0]   rd_r;

  logic        out_valid_q, out_valid_d;
  logic [2:0]  out_kind_q, out_kind_d;
  logic [3:0]  out_proc_q, out_proc_d;
  logic        out_final_q, out_final_d;
  logic        push, slot_free;

  logic        in_acc, p_ok, r_ok;
  cmd_e        cmd;
  amt_t        amt_in;
  logic        j_last, i_last, e_last, safe, repeat_pass;
  amt_t        alloc_val, max_val, req_j, avail_j;
  logic [WorkW-1:0] work_j;
  logic signed [CW-1:0] need_s;
  logic        chk_fail, claim_now, avail_now;
  logic [CW-1:0] sum;
  logic [WorkW-1:0] sat;

  always_comb begin
    if (num_p_q == 5'd0) begin
      n_eff = NPW'(1);
    end else if (32'(num_p_q) > MAX_PROCESSES) begin
      n_eff = NPW'(MAX_PROCESSES);
    end else begin
      n_eff = NPW'(num_p_q);
    end
    if (num_r_q == 4'd0) begin
      m_eff = MW'(1);
    end else if (32'(num_r_q) > MAX_RESOURCES) begin
      m_eff = MW'(MAX_RESOURCES);
    end else begin
      m_eff = MW'(num_r_q);
    end
  end

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign cmd         = cmd_e'(in_i.command);
  assign amt_in      = AMOUNT_WIDTH'(in_i.value);
  assign p_ok        = 32'(in_i.process) < MAX_PROCESSES;
  assign r_ok        = 32'(in_i.resource) < MAX_RESOURCES;
  assign cfg_i.ready = 1'b1;

  assign j_last = (MW'(j_q) + MW'(1)) == m_eff;
  assign i_last = (NPW'(i_q) + NPW'(1)) == n_eff;
  assign e_last = (e_q + NPW'(1)) == n_eff;
  assign safe   = (cnt_q == n_eff);
  assign repeat_pass = prog_q && (cnt_q < n_eff);

  assign alloc_val = alloc_rv_q ? alloc_rd_q : '0;
  assign max_val   = max_rv_q ? max_rd_q : '0;
  assign req_j     = req_q[j_q];
  assign avail_j   = avail_q[j_q];
  assign work_j    = work_q[j_q];
  assign need_s    = $signed(CW'(max_val)) - $signed(CW'(alloc_val));
  assign chk_fail  = need_s > $signed(CW'(work_j));
  assign claim_now = $signed(CW'(req_j)) > need_s;
  assign avail_now = req_j > avail_j;
  assign sum       = CW'(work_j) + CW'(alloc_val);
  assign sat       = (sum > CW'(WorkMax)) ? WorkMax : WorkW'(sum);

  assign slot_free = !out_valid_q || out_o.ready;
  assign rd_addr   = addr_of(rd_p, rd_r);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && cmd == CMD_CHECK) begin
          state_d = ST_INIT;
        end else if (in_acc && cmd == CMD_REQ && in_i.last) begin
          state_d = p_ok ? ST_RQ : ST_ONE;
        end
      end
      ST_INIT: state_d = ST_PROC;
      ST_PROC: begin
        if (fin_q[i_q]) begin
          state_d = (i_last && !repeat_pass) ? ST_SDONE : ST_PROC;
        end else begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (chk_fail) begin
          state_d = (i_last && !repeat_pass) ? ST_SDONE : ST_PROC;
        end else if (j_last) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        if (j_last) begin
          state_d = (i_last && !repeat_pass) ? ST_SDONE : ST_PROC;
        end
      end
      ST_SDONE: begin
        if (req_mode_q) begin
          state_d = safe ? ST_MARK : ST_RB;
        end else begin
          state_d = safe ? ST_EMIT : ST_ONE;
        end
      end
      ST_EMIT: if (slot_free && e_last) state_d = ST_IDLE;
      ST_MARK: if (slot_free) state_d = ST_EMIT;
      ST_ONE:  if (slot_free) state_d = ST_IDLE;
      ST_RQ: begin
        if (j_last) begin
          state_d = (bad_claim_q || claim_now || bad_avail_q || avail_now) ? ST_ONE : ST_GR;
        end
      end
      ST_GR: if (j_last) state_d = ST_INIT;
      ST_RB: if (j_last) state_d = ST_ONE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs of the sequencer.
  always_comb begin
    i_d = i_q;  j_d = j_q;  cnt_d = cnt_q;  e_d = e_q;  prog_d = prog_q;
    req_mode_d = req_mode_q;  bad_claim_d = bad_claim_q;  bad_avail_d = bad_avail_q;
    p_d = p_q;  res_kind_d = res_kind_q;
    fin_d = fin_q;  seq_d = seq_q;  avail_d = avail_q;  req_d = req_q;  work_d = work_q;
    num_p_d = num_p_q;  num_r_d = num_r_q;
    alloc_we = 1'b0;  alloc_waddr = addr_of(p_q, j_q);  alloc_wdata = '0;
    max_we = 1'b0;  max_waddr = addr_of(p_q, j_q);  max_wdata = '0;
    rd_p = i_q;  rd_r = j_q;
    push = 1'b0;
    out_kind_d = out_kind_q;  out_proc_d = out_proc_q;  out_final_d = out_final_q;

    if (cfg_i.valid) begin
      if (cfg_i.index == CfgIdxProcesses) num_p_d = cfg_i.data[4:0];
      if (cfg_i.index == CfgIdxResources) num_r_d = cfg_i.data[3:0];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (cmd)
            CMD_ALLOC: begin
              alloc_we    = p_ok && r_ok;
              alloc_waddr = addr_of(PW'(in_i.process), RW'(in_i.resource));
              alloc_wdata = amt_in;
            end
            CMD_MAX: begin
              max_we    = p_ok && r_ok;
              max_waddr = addr_of(PW'(in_i.process), RW'(in_i.resource));
              max_wdata = amt_in;
            end
            CMD_AVAIL: if (r_ok) avail_d[RW'(in_i.resource)] = amt_in;
            CMD_CHECK: req_mode_d = 1'b0;
            CMD_REQ: begin
              if (r_ok) req_d[RW'(in_i.resource)] = amt_in;
              if (in_i.last) begin
                req_mode_d  = 1'b1;
                p_d         = PW'(in_i.process);
                res_kind_d  = KIND_CLAIM;
                j_d         = '0;
                bad_claim_d = 1'b0;
                bad_avail_d = 1'b0;
                rd_p        = PW'(in_i.process);
                rd_r        = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        for (int k = 0; k < MAX_RESOURCES; k++) work_d[k] = WorkW'(avail_q[k]);
        fin_d = '0;  i_d = '0;  j_d = '0;  cnt_d = '0;  prog_d = 1'b0;
      end
      ST_PROC: begin
        if (fin_q[i_q]) begin
          j_d = '0;
          i_d = i_last ? '0 : i_q + PW'(1);
          if (i_last) prog_d = 1'b0;
        end
      end
      ST_CHK: begin
        if (chk_fail) begin
          j_d = '0;
          i_d = i_last ? '0 : i_q + PW'(1);
          if (i_last) prog_d = 1'b0;
        end else if (j_last) begin
          fin_d[i_q] = 1'b1;
          seq_d[cnt_q[PW-1:0]] = i_q;
          cnt_d  = cnt_q + NPW'(1);
          prog_d = 1'b1;
          j_d    = '0;
          rd_r   = '0;
        end else begin
          j_d  = j_q + RW'(1);
          rd_r = j_q + RW'(1);
        end
      end
      ST_ADD: begin
        work_d[j_q] = sat;
        if (j_last) begin
          j_d = '0;
          i_d = i_last ? '0 : i_q + PW'(1);
          if (i_last) prog_d = 1'b0;
        end else begin
          j_d  = j_q + RW'(1);
          rd_r = j_q + RW'(1);
        end
      end
      ST_SDONE: begin
        e_d  = '0;
        j_d  = '0;
        rd_p = p_q;
        rd_r = '0;
        res_kind_d = KIND_UNSAFE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          push        = 1'b1;
          out_kind_d  = KIND_SEQ;
          out_proc_d  = 4'(seq_q[e_q[PW-1:0]]);
          out_final_d = e_last;
          e_d         = e_q + NPW'(1);
        end
      end
      ST_MARK: begin
        if (slot_free) begin
          push        = 1'b1;
          out_kind_d  = KIND_GRANT;
          out_proc_d  = 4'(p_q);
          out_final_d = 1'b0;
        end
      end
      ST_ONE: begin
        if (slot_free) begin
          push        = 1'b1;
          out_kind_d  = res_kind_q;
          out_proc_d  = 4'd0;
          out_final_d = 1'b1;
        end
      end
      ST_RQ: begin
        rd_p        = p_q;
        bad_claim_d = bad_claim_q || claim_now;
        bad_avail_d = bad_avail_q || avail_now;
        res_kind_d  = (bad_claim_q || claim_now) ? KIND_CLAIM : KIND_UNAVAIL;
        if (j_last) begin
          j_d  = '0;
          rd_r = '0;
        end else begin
          j_d  = j_q + RW'(1);
          rd_r = j_q + RW'(1);
        end
      end
      ST_GR, ST_RB: begin
        rd_p     = p_q;
        alloc_we = 1'b1;
        if (state_q == ST_GR) begin
          alloc_wdata  = alloc_val + req_j;
          avail_d[j_q] = avail_j - req_j;
        end else begin
          alloc_wdata  = alloc_val - req_j;
          avail_d[j_q] = avail_j + req_j;
        end
        if (j_last) begin
          j_d = '0;
        end else begin
          j_d  = j_q + RW'(1);
          rd_r = j_q + RW'(1);
        end
      end
      default: ;
    endcase

    out_valid_d = push ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i) begin
    if (alloc_we) alloc_mem[alloc_waddr] <= alloc_wdata;
    if (max_we) max_mem[max_waddr] <= max_wdata;
    alloc_rd_q <= alloc_mem[rd_addr];
    max_rd_q   <= max_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alloc_vld_q <= '0;
      max_vld_q   <= '0;
      alloc_rv_q  <= 1'b0;
      max_rv_q    <= 1'b0;
    end else begin
      if (alloc_we) alloc_vld_q[alloc_waddr] <= 1'b1;
      if (max_we) max_vld_q[max_waddr] <= 1'b1;
      alloc_rv_q <= alloc_vld_q[rd_addr];
      max_rv_q   <= max_vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      num_p_q     <= 5'd1;
      num_r_q     <= 4'd1;
      i_q         <= '0;
      j_q         <= '0;
      cnt_q       <= '0;
      e_q         <= '0;
      prog_q      <= 1'b0;
      req_mode_q  <= 1'b0;
      bad_claim_q <= 1'b0;
      bad_avail_q <= 1'b0;
      fin_q       <= '0;
      avail_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      num_p_q     <= num_p_d;
      num_r_q     <= num_r_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cnt_q       <= cnt_d;
      e_q         <= e_d;
      prog_q      <= prog_d;
      req_mode_q  <= req_mode_d;
      bad_claim_q <= bad_claim_d;
      bad_avail_q <= bad_avail_d;
      fin_q       <= fin_d;
      avail_q     <= avail_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q         <= p_d;
    res_kind_q  <= res_kind_d;
    seq_q       <= seq_d;
    req_q       <= req_d;
    work_q      <= work_d;
    out_kind_q  <= out_kind_d;
    out_proc_q  <= out_proc_d;
    out_final_q <= out_final_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.kind          = out_kind_q;
  assign out_o.process_index = out_proc_q;
  assign out_o.final_res     = out_final_q;

  // The sequence is only ever sent once every process has finished.
  a_emit_safe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (cnt_q == n_eff))
    else $error("sequence sent for an unsafe state");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= NPW'(MAX_PROCESSES))
    else $error("finish count beyond process count");

  // A tentative grant follows only a clean claim and availability scan.
  a_grant_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GR) |-> (!bad_claim_q && !bad_avail_q))
    else $error("grant after a refused request");

  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> slot_free)
    else $error("result register overwritten");

  a_final_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_final_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after the final result");

endmodule
`default_nettype wire
